@@ hw/rtl/cron_next_match_search_macros.svh @@
// Assertion macros for the cron search RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef CRON_NEXT_MATCH_SEARCH_MACROS_SVH
`define CRON_NEXT_MATCH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CNMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/cnms_pkg.sv @@
// Types, constants and calendar helpers for the cron next-match search.
// Used by cnms_ctrl, cnms_dp and cron_next_match_search.
`timescale 1ns / 1ps

package cnms_pkg;

    localparam int SEARCH_YEARS = 400;
    localparam int CNT_W        = $clog2(SEARCH_YEARS + 1);
    localparam int YS_MAX       = 32768 - SEARCH_YEARS;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [2:0] REG_MINUTE  = 3'd0;
    localparam logic [2:0] REG_HOUR    = 3'd1;
    localparam logic [2:0] REG_DAY     = 3'd2;
    localparam logic [2:0] REG_MONTH   = 3'd3;
    localparam logic [2:0] REG_WEEKDAY = 3'd4;

    // floor(x/100) = (x*RECIP100)>>23, x < 91199; floor(x/7) = (x*RECIP7)>>20, x < 2^17
    localparam logic [16:0] RECIP100 = 17'd83887;
    localparam logic [17:0] RECIP7   = 18'd149797;

    typedef struct packed {
        logic load;
        logic init;
        logic scan;
    } t_cmd;

    typedef struct packed {
        logic early;
        logic hit;
        logic exhausted;
    } t_status;

    function automatic logic [2:0] wd_offset(input logic [3:0] m);
        logic [2:0] r;
        case (m)
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] lowest_bit(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) r = 6'(i);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cnms_dp.sv @@
// Datapath of the cron search: start-date set-up pipeline, day walker, result registers.
// Depends on cnms_pkg; driven by cnms_ctrl.
`timescale 1ns / 1ps

module cnms_dp import cnms_pkg::*; (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [59:0]        i_minute_mask,
    input  logic [23:0]        i_hour_mask,
    input  logic [30:0]        i_day_mask,
    input  logic [11:0]        i_month_mask,
    input  logic [6:0]         i_weekday_mask,
    input  logic signed [15:0] i_from_year,
    input  logic [3:0]         i_from_month,
    input  logic [4:0]         i_from_day,
    input  logic [4:0]         i_from_hour,
    input  logic [5:0]         i_from_minute,
    output logic [1:0]         o_status_code,
    output logic signed [15:0] o_next_year,
    output logic [3:0]         o_next_month,
    output logic [4:0]         o_next_day,
    output logic [4:0]         o_next_hour,
    output logic [5:0]         o_next_minute
);

    // captured request
    logic signed [15:0] r_ys;
    logic [3:0]  r_lm;
    logic [4:0]  r_ld, r_lh;
    logic [5:0]  r_lmi;

    // stage 1
    logic [15:0] r_y0;
    logic [3:0]  r_m0;
    logic [CNT_W-1:0] r_cnt0;
    logic [16:0] r_s0, r_sa;
    logic [33:0] r_p0, r_pa;
    // stage 2
    logic [16:0] r_sum;
    logic [6:0]  r_r100_0;
    logic [8:0]  r_r400_0;
    logic        r_early;
    logic [1:0]  r_early_code;
    logic        r_bnd_ok;
    logic [4:0]  r_bnd_h, r_fh;
    logic [5:0]  r_bnd_m, r_fm;
    // stage 3
    logic [34:0] r_p7;
    // walker
    logic signed [15:0] r_y;
    logic [3:0]  r_m;
    logic [4:0]  r_d;
    logic [2:0]  r_wd;
    logic [CNT_W-1:0] r_cnt;
    logic [6:0]  r_r100;
    logic [8:0]  r_r400;
    logic        r_first;
    // result
    logic [1:0]  r_code;
    logic [15:0] r_ny;
    logic [3:0]  r_nm;
    logic [4:0]  r_nd, r_nh;
    logic [5:0]  r_nmi;

    // stage 1 logic
    logic [15:0] n_y0;
    logic [3:0]  n_m0;
    logic [16:0] n_s0, n_sa;
    always_comb begin
        n_y0 = (r_lm > 4'd12) ? 16'(r_ys + 16'sd1) : r_ys;
        n_m0 = (r_lm == 4'd0 || r_lm > 4'd12) ? 4'd1 : r_lm;
        n_s0 = 17'({n_y0[15], n_y0} + 17'd40000);
        n_sa = (n_m0 < 4'd3) ? 17'(n_s0 - 17'd1) : n_s0;
    end

    // stage 2 logic
    logic [10:0] qa, q0;
    logic [16:0] n_sum;
    logic [6:0]  n_r100;
    logic        ys_low, ys_high, ys_top, n_early;
    logic [59:0] above;
    logic [23:0] hgt;
    logic        heq, m_ok, h_eq_ok;
    logic [5:0]  bm, fm;
    logic [4:0]  fh, hg;
    always_comb begin
        qa    = r_pa[33:23];
        q0    = r_p0[33:23];
        n_sum = 17'(r_sa + (r_sa >> 2) - 17'(qa) + 17'(qa >> 2)
                    + 17'(wd_offset(r_m0)) + 17'd1);
        n_r100 = 7'(r_s0 - 17'(q0 * 11'd100));
        ys_low  = (r_ys == 16'sh8000);
        ys_high = (r_ys > 16'(YS_MAX));
        ys_top  = (r_ys == 16'sh7fff) && ((r_lm > 4'd12) || (r_lm == 4'd12
                  && r_ld == 5'd31 && (r_lh > 5'd23 || (r_lh == 5'd23 && r_lmi >= 6'd59))));
        n_early = ys_low || ys_high || ys_top || (i_minute_mask == '0) || (i_hour_mask == '0);
        for (int i = 0; i < 60; i++) begin
            above[i] = i_minute_mask[i] && (6'(i) > r_lmi);
        end
        heq = 1'b0;
        for (int i = 0; i < 24; i++) begin
            hgt[i] = i_hour_mask[i] && (5'(i) > r_lh);
            if (i_hour_mask[i] && (5'(i) == r_lh)) heq = 1'b1;
        end
        m_ok    = (r_lmi < 6'd59) && (above != '0);
        h_eq_ok = heq && m_ok;
        bm = lowest_bit({4'd0, above});
        fm = lowest_bit({4'd0, i_minute_mask});
        fh = 5'(lowest_bit({40'd0, i_hour_mask}));
        hg = 5'(lowest_bit({40'd0, hgt}));
    end

    // walker logic
    logic        leap, mbit, bound_day, hit;
    logic [4:0]  dim;
    logic [2:0]  wd_inc, wd_skip;
    logic [3:0]  wd_sum;
    always_comb begin
        leap      = (r_y[1:0] == 2'd0 && r_r100 != 7'd0) || (r_r400 == 9'd0);
        dim       = month_len(r_m, leap);
        mbit      = i_month_mask[r_m - 4'd1];
        bound_day = r_first && (r_m == r_lm) && (r_d == r_ld);
        hit = mbit && i_day_mask[r_d - 5'd1] && i_weekday_mask[r_wd]
              && !(r_first && r_m == r_lm && r_d < r_ld)
              && !(bound_day && !r_bnd_ok);
        wd_inc  = (r_wd == 3'd6) ? 3'd0 : 3'(r_wd + 3'd1);
        wd_sum  = 4'(r_wd) + 4'(dim - 5'd28);
        wd_skip = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : 3'(wd_sum);
    end

    assign o_status.early     = r_early;
    assign o_status.exhausted = (r_cnt == CNT_W'(SEARCH_YEARS));
    assign o_status.hit       = hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ys  <= i_from_year;
            r_lm  <= i_from_month;
            r_ld  <= i_from_day;
            r_lh  <= i_from_hour;
            r_lmi <= i_from_minute;
        end
        // set-up pipeline runs freely off the held request
        r_y0   <= n_y0;
        r_m0   <= n_m0;
        r_cnt0 <= (r_lm > 4'd12) ? CNT_W'(1) : '0;
        r_s0   <= n_s0;
        r_sa   <= n_sa;
        r_p0   <= n_s0 * RECIP100;
        r_pa   <= n_sa * RECIP100;

        r_sum        <= n_sum;
        r_r100_0     <= n_r100;
        r_r400_0     <= 9'(n_r100) + 9'(q0[1:0] * 9'd100);
        r_early      <= n_early;
        r_early_code <= (ys_low || ys_high || ys_top) ? ST_RANGE : ST_NONE;
        r_bnd_ok     <= h_eq_ok || (hgt != '0);
        r_bnd_h      <= h_eq_ok ? r_lh : hg;
        r_bnd_m      <= h_eq_ok ? bm : fm;
        r_fh         <= fh;
        r_fm         <= fm;

        r_p7 <= r_sum * RECIP7;

        if (i_cmd.init) begin
            r_y     <= r_y0;
            r_m     <= r_m0;
            r_d     <= 5'd1;
            r_wd    <= 3'(r_sum - 17'(r_p7[34:20] * 15'd7));
            r_cnt   <= r_cnt0;
            r_first <= (r_cnt0 == '0);
            r_r100  <= r_r100_0;
            r_r400  <= r_r400_0;
            if (r_early) begin
                r_code <= r_early_code;
                r_ny <= '0; r_nm <= '0; r_nd <= '0; r_nh <= '0; r_nmi <= '0;
            end
        end else if (i_cmd.scan) begin
            if (o_status.exhausted) begin
                r_code <= ST_NONE;
                r_ny <= '0; r_nm <= '0; r_nd <= '0; r_nh <= '0; r_nmi <= '0;
            end else if (hit) begin
                r_code <= ST_FOUND;
                r_ny   <= r_y;
                r_nm   <= r_m;
                r_nd   <= r_d;
                r_nh   <= bound_day ? r_bnd_h : r_fh;
                r_nmi  <= bound_day ? r_bnd_m : r_fm;
            end else begin
                // drop a whole month in one step when its bit is clear
                if (!mbit || r_d == dim) begin
                    r_wd <= mbit ? wd_inc : wd_skip;
                    r_d  <= 5'd1;
                    if (r_m == 4'd12) begin
                        r_m     <= 4'd1;
                        r_y     <= 16'(r_y + 16'sd1);
                        r_cnt   <= CNT_W'(r_cnt + 1'b1);
                        r_first <= 1'b0;
                        r_r100  <= (r_r100 == 7'd99)  ? 7'd0 : 7'(r_r100 + 7'd1);
                        r_r400  <= (r_r400 == 9'd399) ? 9'd0 : 9'(r_r400 + 9'd1);
                    end else begin
                        r_m <= 4'(r_m + 4'd1);
                    end
                end else begin
                    r_wd <= wd_inc;
                    r_d  <= 5'(r_d + 5'd1);
                end
            end
        end
    end

    assign o_status_code = r_code;
    assign o_next_year   = r_ny;
    assign o_next_month  = r_nm;
    assign o_next_day    = r_nd;
    assign o_next_hour   = r_nh;
    assign o_next_minute = r_nmi;

endmodule

@@ hw/rtl/cnms_ctrl.sv @@
// Controller of the cron search: sequences set-up, the day walk and result hand-off.
// Depends on cnms_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cron_next_match_search_macros.svh"

module cnms_ctrl import cnms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE, S_P1, S_P2, S_P3, S_P4, S_SCAN, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_P1;
            end
            S_P1: n_state = S_P2;
            S_P2: n_state = S_P3;
            S_P3: n_state = S_P4;
            S_P4: begin
                o_cmd.init = 1'b1;
                if (i_status.early) begin
                    n_state     = S_DONE;
                    n_out_valid = 1'b1;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit || i_status.exhausted) begin
                    n_state     = S_DONE;
                    n_out_valid = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `CNMS_ASSERT_IMPL(a_one_at_a_time, i_clk, i_rst_n, r_out_valid, o_in_stall)
    `CNMS_ASSERT_IMPL(a_valid_in_done, i_clk, i_rst_n, r_out_valid, r_state == S_DONE)
    `CNMS_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)

endmodule

@@ hw/rtl/cron_next_match_search.sv @@
// Top level of the cron next-match search: APB register file, controller, datapath.
// Depends on cnms_pkg, cnms_ctrl and cnms_dp.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  request  | i_in_valid / o_in_stall | i_from_year/month/day/hour/minute
//  result   | o_out_valid/i_out_stall | o_status, o_next_year/month/day/hour/minute
//  config   | psel/penable/pready     | paddr, pwdata, prdata (64-bit, 8-byte stride)
//
// One request at a time: set-up through states S_P1 to S_P4, then one cycle per calendar day
// walked by the day walker in the datapath, a month whose bit is clear being skipped as a whole;
// the result then waits for i_out_stall low.
// Reset is synchronous and active low; the masks come out of reset all ones.
`timescale 1ns / 1ps

module cron_next_match_search import cnms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_from_year,
    input  logic [3:0]         i_from_month,
    input  logic [4:0]         i_from_day,
    input  logic [4:0]         i_from_hour,
    input  logic [5:0]         i_from_minute,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_next_year,
    output logic [3:0]         o_next_month,
    output logic [4:0]         o_next_day,
    output logic [4:0]         o_next_hour,
    output logic [5:0]         o_next_minute
);

    logic [59:0] r_minute_mask;
    logic [23:0] r_hour_mask;
    logic [30:0] r_day_mask;
    logic [11:0] r_month_mask;
    logic [6:0]  r_weekday_mask;
    logic        wr_en;
    t_cmd        cmd;
    t_status     status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute_mask  <= '1;
            r_hour_mask    <= '1;
            r_day_mask     <= '1;
            r_month_mask   <= '1;
            r_weekday_mask <= '1;
        end else if (wr_en) begin
            unique case (paddr[5:3])
                REG_MINUTE:  r_minute_mask  <= pwdata[59:0];
                REG_HOUR:    r_hour_mask    <= pwdata[23:0];
                REG_DAY:     r_day_mask     <= pwdata[30:0];
                REG_MONTH:   r_month_mask   <= pwdata[11:0];
                REG_WEEKDAY: r_weekday_mask <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_MINUTE:  prdata = 64'(r_minute_mask);
            REG_HOUR:    prdata = 64'(r_hour_mask);
            REG_DAY:     prdata = 64'(r_day_mask);
            REG_MONTH:   prdata = 64'(r_month_mask);
            REG_WEEKDAY: prdata = 64'(r_weekday_mask);
            default:     prdata = '0;
        endcase
    end

    cnms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    cnms_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_minute_mask  (r_minute_mask),
        .i_hour_mask    (r_hour_mask),
        .i_day_mask     (r_day_mask),
        .i_month_mask   (r_month_mask),
        .i_weekday_mask (r_weekday_mask),
        .i_from_year    (i_from_year),
        .i_from_month   (i_from_month),
        .i_from_day     (i_from_day),
        .i_from_hour    (i_from_hour),
        .i_from_minute  (i_from_minute),
        .o_status_code  (o_status),
        .o_next_year    (o_next_year),
        .o_next_month   (o_next_month),
        .o_next_day     (o_next_day),
        .o_next_hour    (o_next_hour),
        .o_next_minute  (o_next_minute)
    );

endmodule
